// ===== src/hbp_pkg.sv =====
// shared constants and types of the height map box placement engine
`timescale 1ns / 1ps

package hbp_pkg;

	// default geometry of the floor grid
	localparam int DEF_GRID_ROWS   = 32;
	localparam int DEF_GRID_COLS   = 32;
	localparam int DEF_HEIGHT_BITS = 10;

	// fixed field widths of the channels
	localparam int POS_W     = 5;
	localparam int LEN_W     = 6;
	localparam int TALL_W    = 10;
	localparam int LVL_W     = 10;
	localparam int CNT_OUT_W = 11;
	localparam int CH_W      = 10;
	localparam int AREA_W    = 2 * LEN_W;

	// container height after reset
	localparam logic [CH_W-1:0] CH_RESET = 10'd1023;

	// request kinds
	typedef enum logic {
		REQ_QUERY = 1'b0,
		REQ_PLACE = 1'b1
	} hbp_req_kind_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} hbp_state_t;

endpackage

// ===== src/hbp_if.sv =====
// valid/ready channel interfaces for request, response and configuration
`timescale 1ns / 1ps

interface hbp_req_if import hbp_pkg::*;;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [POS_W-1:0]  pos_x;
	logic [POS_W-1:0]  pos_y;
	logic [LEN_W-1:0]  box_len;
	logic [LEN_W-1:0]  box_wid;
	logic [TALL_W-1:0] box_tall;

	modport source (output valid, req_type, pos_x, pos_y, box_len, box_wid, box_tall,
		input ready);
	modport sink (input valid, req_type, pos_x, pos_y, box_len, box_wid, box_tall,
		output ready);
endinterface

interface hbp_rsp_if import hbp_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic                 fits;
	logic [LVL_W-1:0]     base_level;
	logic [CNT_OUT_W-1:0] contact_cells;

	modport source (output valid, fits, base_level, contact_cells, input ready);
	modport sink (input valid, fits, base_level, contact_cells, output ready);
endinterface

interface hbp_cfg_if import hbp_pkg::*;;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] container_height;

	modport source (output valid, container_height, input ready);
	modport sink (input valid, container_height, output ready);
endinterface

// ===== src/hbp_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module hbp_ram import hbp_pkg::*; #(
	parameter int WIDTH = DEF_GRID_COLS * DEF_HEIGHT_BITS,
	parameter int DEPTH = DEF_GRID_ROWS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/hbp_row_reduce.sv =====
// max and tie count over the footprint cells of one row word, registered root
`timescale 1ns / 1ps

module hbp_row_reduce import hbp_pkg::*; #(
	parameter int GRID_COLS   = DEF_GRID_COLS,
	parameter int HEIGHT_BITS = DEF_HEIGHT_BITS,
	localparam int ROW_W = GRID_COLS * HEIGHT_BITS,
	localparam int RC_W  = $clog2(GRID_COLS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_vld,
	input  logic [ROW_W-1:0]       row_cells,
	input  logic [GRID_COLS-1:0]   col_mask,
	output logic                   vld_s2,
	output logic [HEIGHT_BITS-1:0] max_s2,
	output logic [RC_W-1:0]        cnt_s2
);

	localparam int LVLS = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 0;
	localparam int P    = 1 << LVLS;

	// heap ordered tree nodes, leaves at P-1 .. 2P-2
	logic [HEIGHT_BITS-1:0] node_v [2*P-1];
	logic [RC_W-1:0]        node_c [2*P-1];

	// leaves: cells outside the footprint count as nothing
	for (genvar i = 0; i < P; i++) begin : g_leaf
		if (i < GRID_COLS) begin : g_used
			assign node_v[P-1+i] = col_mask[i] ? row_cells[i*HEIGHT_BITS +: HEIGHT_BITS] : '0;
			assign node_c[P-1+i] = RC_W'(col_mask[i]);
		end else begin : g_pad
			assign node_v[P-1+i] = '0;
			assign node_c[P-1+i] = '0;
		end
	end

	// merge pairs: keep the higher, add tie counts on equal heights
	for (genvar i = 0; i < P - 1; i++) begin : g_node
		logic a_gt, a_eq;
		assign a_gt      = node_v[2*i+1] > node_v[2*i+2];
		assign a_eq      = node_v[2*i+1] == node_v[2*i+2];
		assign node_v[i] = a_gt ? node_v[2*i+1] : node_v[2*i+2];
		assign node_c[i] = a_eq ? (node_c[2*i+1] + node_c[2*i+2]) :
			(a_gt ? node_c[2*i+1] : node_c[2*i+2]);
	end

	// valid of the root register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= in_vld;
		end
	end

	// root register
	always_ff @(posedge clk) begin
		if (in_vld) begin
			max_s2 <= node_v[0];
			cnt_s2 <= node_c[0];
		end
	end

endmodule

// ===== src/hbp_row_update.sv =====
// saturating height add over the footprint cells of one row word
`timescale 1ns / 1ps

module hbp_row_update import hbp_pkg::*; #(
	parameter int GRID_COLS   = DEF_GRID_COLS,
	parameter int HEIGHT_BITS = DEF_HEIGHT_BITS,
	localparam int ROW_W = GRID_COLS * HEIGHT_BITS
) (
	input  logic [ROW_W-1:0]       row_cells,
	input  logic [GRID_COLS-1:0]   col_mask,
	input  logic [TALL_W-1:0]      tall,
	input  logic [HEIGHT_BITS-1:0] cap,
	output logic [ROW_W-1:0]       row_new
);

	localparam int SW = ((HEIGHT_BITS > TALL_W) ? HEIGHT_BITS : TALL_W) + 1;

	// one lane per column; a cell already above the cap stays where it is
	for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
		logic [HEIGHT_BITS-1:0] h, lim;
		logic [SW-1:0]          sum;
		logic [HEIGHT_BITS-1:0] sat;
		assign h   = row_cells[c*HEIGHT_BITS +: HEIGHT_BITS];
		assign lim = (h > cap) ? h : cap;
		assign sum = SW'(h) + SW'(tall);
		assign sat = (sum > SW'(lim)) ? lim : HEIGHT_BITS'(sum);
		assign row_new[c*HEIGHT_BITS +: HEIGHT_BITS] = col_mask[c] ? sat : h;
	end

endmodule

// ===== src/heightmap_box_placement_engine.sv =====
// top level: height map box placement engine
//
//  channel | dir | fields                                           | request taken
//  cfg     | in  | container_height                                 | cfg.valid & cfg.ready
//  req     | in  | req_type pos_x pos_y box_len box_wid box_tall    | req.valid & req.ready
//  rsp     | out | fits base_level contact_cells                     | rsp.valid & rsp.ready
//
// for an in-bounds request one floor row word is read per cycle from the height
// map ram, reduced in a registered tree and written back in the same pass for a
// place request; an empty or off-map footprint reads no row
// reset clears one valid bit per row, an unwritten row reads as all zero
// a finished result waits while the response register is full, and no new
// request is taken until it has moved there; configuration is always ready
`timescale 1ns / 1ps

module heightmap_box_placement_engine import hbp_pkg::*; #(
	parameter int GRID_ROWS   = DEF_GRID_ROWS,
	parameter int GRID_COLS   = DEF_GRID_COLS,
	parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
	input logic       clk,
	input logic       arst_n,
	hbp_cfg_if.sink   cfg,
	hbp_req_if.sink   req,
	hbp_rsp_if.source rsp
);

	localparam int RA_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int ROW_W = GRID_COLS * HEIGHT_BITS;
	localparam int RC_W  = $clog2(GRID_COLS + 1);
	localparam int CNT_W = $clog2(GRID_ROWS * GRID_COLS + 1);
	localparam int EXT_W = ((HEIGHT_BITS > CH_W) ? HEIGHT_BITS : CH_W) + 1;
	localparam int FW    = ((CNT_W + 1 > AREA_W) ? CNT_W + 1 : AREA_W);
	localparam logic [HEIGHT_BITS-1:0] HMAX = {HEIGHT_BITS{1'b1}};

	hbp_state_t state_q, state_d;

	logic [CH_W-1:0]        ch_q;
	logic                   place_q;
	logic [TALL_W-1:0]      tall_q;
	logic [GRID_COLS-1:0]   mask_q;
	logic [AREA_W-1:0]      area_q;
	logic [RA_W-1:0]        row_q;
	logic [LEN_W-1:0]       left_q;
	logic                   bad_q;
	logic [HEIGHT_BITS-1:0] top_q;
	logic [CNT_W-1:0]       count_q;
	logic [GRID_ROWS-1:0]   row_vld_q;

	logic                   vld_s1, row_vld_s1;
	logic [RA_W-1:0]        addr_s1;
	logic                   vld_s2;
	logic [HEIGHT_BITS-1:0] max_s2;
	logic [RC_W-1:0]        cnt_s2;

	logic                   out_vld_q, fits_q;
	logic [LVL_W-1:0]       base_q;
	logic [CNT_OUT_W-1:0]   contact_q;

	logic                   req_take, bad_d, rd_en, wr_en, load_out, slot_free, fits_d;
	logic [GRID_COLS-1:0]   mask_d;
	logic [ROW_W-1:0]       rd_data, cells_s1, row_new;
	logic [HEIGHT_BITS-1:0] cap;

	// configuration register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= CH_RESET;
		end else if (cfg.valid) begin
			ch_q <= cfg.container_height;
		end
	end

	// footprint checks at request time
	assign req_take = req.valid && req.ready;
	assign bad_d = (req.box_len == '0) || (req.box_wid == '0) ||
		(int'(req.pos_x) + int'(req.box_len) > GRID_ROWS) ||
		(int'(req.pos_y) + int'(req.box_wid) > GRID_COLS);
	for (genvar c = 0; c < GRID_COLS; c++) begin : g_mask
		assign mask_d[c] = (c >= int'(req.pos_y)) &&
			(c < int'(req.pos_y) + int'(req.box_wid));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_take) state_d = bad_d ? ST_FINISH : ST_SCAN;
			end
			ST_SCAN: begin
				if (left_q == LEN_W'(1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!vld_s1 && !vld_s2) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	assign slot_free = !out_vld_q || rsp.ready;
	always_comb begin
		req.ready = 1'b0;
		rd_en     = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE:   req.ready = 1'b1;
			ST_SCAN:   rd_en     = 1'b1;
			ST_DRAIN:  ;
			ST_FINISH: load_out  = slot_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request context and row walker
	always_ff @(posedge clk) begin
		if (req_take) begin
			place_q <= (req.req_type == REQ_PLACE);
			tall_q  <= req.box_tall;
			mask_q  <= mask_d;
			area_q  <= AREA_W'(req.box_len) * AREA_W'(req.box_wid);
			row_q   <= RA_W'(req.pos_x);
			left_q  <= req.box_len;
			bad_q   <= bad_d;
		end else if (rd_en) begin
			row_q  <= row_q + RA_W'(1);
			left_q <= left_q - LEN_W'(1);
		end
	end

	// read stage bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
		end
	end
	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1    <= row_q;
			row_vld_s1 <= row_vld_q[row_q];
		end
	end

	// per row valid bits, set on write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr_en) begin
			row_vld_q[addr_s1] <= 1'b1;
		end
	end

	// height map ram, one row word per entry
	hbp_ram #(
		.WIDTH(ROW_W),
		.DEPTH(GRID_ROWS)
	) u_map (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(addr_s1),
		.wr_data(row_new),
		.rd_en(rd_en),
		.rd_addr(row_q),
		.rd_data(rd_data)
	);

	assign cells_s1 = row_vld_s1 ? rd_data : '0;

	// row max and tie count
	hbp_row_reduce #(
		.GRID_COLS(GRID_COLS),
		.HEIGHT_BITS(HEIGHT_BITS)
	) u_reduce (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(vld_s1),
		.row_cells(cells_s1),
		.col_mask(mask_q),
		.vld_s2(vld_s2),
		.max_s2(max_s2),
		.cnt_s2(cnt_s2)
	);

	// write back of the raised row for a place request
	assign cap   = (EXT_W'(ch_q) < EXT_W'(HMAX)) ? HEIGHT_BITS'(ch_q) : HMAX;
	assign wr_en = vld_s1 && place_q;
	hbp_row_update #(
		.GRID_COLS(GRID_COLS),
		.HEIGHT_BITS(HEIGHT_BITS)
	) u_update (
		.row_cells(cells_s1),
		.col_mask(mask_q),
		.tall(tall_q),
		.cap(cap),
		.row_new(row_new)
	);

	// running footprint max and count across rows
	always_ff @(posedge clk) begin
		if (req_take) begin
			top_q   <= '0;
			count_q <= '0;
		end else if (vld_s2) begin
			if (max_s2 > top_q) begin
				top_q   <= max_s2;
				count_q <= CNT_W'(cnt_s2);
			end else if (max_s2 == top_q) begin
				count_q <= count_q + CNT_W'(cnt_s2);
			end
		end
	end

	// fit decision
	assign fits_d = !bad_q &&
		(EXT_W'(top_q) + EXT_W'(tall_q) <= EXT_W'(ch_q)) &&
		(FW'({count_q, 1'b0}) >= FW'(area_q));

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (load_out) begin
			fits_q    <= fits_d;
			base_q    <= LVL_W'(top_q);
			contact_q <= CNT_OUT_W'(count_q);
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.fits          = fits_q;
	assign rsp.base_level    = base_q;
	assign rsp.contact_cells = contact_q;

endmodule

// ===== dv/hbp_placement_checker.sv =====
// checker for the height map box placement engine: tracks the floor and scores every response
`timescale 1ns / 1ps

module hbp_placement_checker import hbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	hbp_cfg_if   cfg,
	hbp_req_if   req,
	hbp_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding,
	output int   responses,
	output int   fit_count,
	output int   placed_count,
	output int   skipped_count
);

	localparam int ROWS       = DEF_GRID_ROWS;
	localparam int COLS       = DEF_GRID_COLS;
	localparam int HEIGHT_TOP = (1 << DEF_HEIGHT_BITS) - 1;

	typedef struct {
		logic                 fits;
		logic [LVL_W-1:0]     base_level;
		logic [CNT_OUT_W-1:0] contact_cells;
	} placement_t;

	// shadow floor and container limit
	int         floor_map [ROWS][COLS];
	int         stack_limit;
	placement_t placement_q [$];

	// score one footprint against the floor, then raise it for a place request
	task automatic score_footprint(input logic place, input int px, input int py,
		input int len, input int wid, input int tall, output placement_t res);
		int top_h;
		int hits;
		int h;
		int sum;
		int lim;
		int cap;
		res = '{1'b0, '0, '0};
		top_h = 0;
		hits = 0;
		// empty or off-map footprint leaves the floor alone
		if (len == 0 || wid == 0 || px + len > ROWS || py + wid > COLS) begin
			skipped_count++;
			return;
		end
		for (int x = px; x < px + len; x++) begin
			for (int y = py; y < py + wid; y++) begin
				h = floor_map[x][y];
				if (h > top_h) begin
					top_h = h;
					hits = 1;
				end else if (h == top_h) begin
					hits++;
				end
			end
		end
		res.fits = (top_h + tall <= stack_limit) && (2 * hits >= len * wid);
		res.base_level = top_h[LVL_W-1:0];
		res.contact_cells = hits[CNT_OUT_W-1:0];
		// place goes ahead even without a fit; cells above the cap keep their height
		if (place) begin
			placed_count++;
			cap = (stack_limit < HEIGHT_TOP) ? stack_limit : HEIGHT_TOP;
			for (int x = px; x < px + len; x++) begin
				for (int y = py; y < py + wid; y++) begin
					h = floor_map[x][y];
					sum = h + tall;
					lim = (h > cap) ? h : cap;
					floor_map[x][y] = ((sum > lim) ? lim : sum) & HEIGHT_TOP;
				end
			end
		end
	endtask

	// watch the three channels at each rising clock edge
	always @(posedge clk or negedge arst_n) begin : watch
		placement_t want;
		if (!arst_n) begin
			for (int x = 0; x < ROWS; x++)
				for (int y = 0; y < COLS; y++)
					floor_map[x][y] = 0;
			stack_limit = CH_RESET;
			placement_q.delete();
			mismatches = 0;
			outstanding = 0;
			responses = 0;
			fit_count = 0;
			placed_count = 0;
			skipped_count = 0;
		end else begin
			// container height write
			if (cfg.valid && cfg.ready)
				stack_limit = cfg.container_height;
			// accepted request: predict its response
			if (req.valid && req.ready) begin
				score_footprint(req.req_type == REQ_PLACE, req.pos_x, req.pos_y,
					req.box_len, req.box_wid, req.box_tall, want);
				placement_q = {placement_q, want};
			end
			// accepted response: compare against the oldest prediction
			if (rsp.valid && rsp.ready) begin
				responses++;
				if (rsp.fits === 1'b1)
					fit_count++;
				if (placement_q.size() == 0) begin
					mismatches++;
					$display("%0t checker: response with none expected,", $time,
						" fits=%0b base_level=%0d contact_cells=%0d",
						rsp.fits, rsp.base_level, rsp.contact_cells);
				end else begin
					want = placement_q.pop_front();
					if (rsp.fits !== want.fits || rsp.base_level !== want.base_level ||
						rsp.contact_cells !== want.contact_cells) begin
						mismatches++;
						$display("%0t checker: mismatch, expected", $time,
							" fits=%0b base_level=%0d contact_cells=%0d,",
							want.fits, want.base_level, want.contact_cells,
							" actual fits=%0b base_level=%0d contact_cells=%0d",
							rsp.fits, rsp.base_level, rsp.contact_cells);
					end
				end
			end
			outstanding = placement_q.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// testbench top: reset, stimulus, response back-pressure and verdict for the placement engine
`timescale 1ns / 1ps

module tb_top;
	import hbp_pkg::*;

	localparam int GRID         = DEF_GRID_ROWS;
	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 250;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 60;

	typedef struct {
		hbp_req_kind_t     kind;
		logic [POS_W-1:0]  px;
		logic [POS_W-1:0]  py;
		logic [LEN_W-1:0]  len;
		logic [LEN_W-1:0]  wid;
		logic [TALL_W-1:0] tall;
	} box_req_t;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_MOSTLY,
		RX_SLOW
	} rx_mode_t;

	logic clk;
	logic arst_n;

	hbp_cfg_if cfg ();
	hbp_req_if req ();
	hbp_rsp_if rsp ();

	int mismatches;
	int outstanding;
	int responses;
	int fit_count;
	int placed_count;
	int skipped_count;
	int burst_left;
	int items_sent;
	bit long_hold_req;

	heightmap_box_placement_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

	hbp_placement_checker placement_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.req           (req),
		.rsp           (rsp),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.responses     (responses),
		.fit_count     (fit_count),
		.placed_count  (placed_count),
		.skipped_count (skipped_count)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// reset held at the start only
	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	function automatic box_req_t make_box(input hbp_req_kind_t kind, input int px,
		input int py, input int len, input int wid, input int tall);
		box_req_t b;
		b.kind = kind;
		b.px = POS_W'(px);
		b.py = POS_W'(py);
		b.len = LEN_W'(len);
		b.wid = LEN_W'(wid);
		b.tall = TALL_W'(tall);
		return b;
	endfunction

	// mostly in-bounds footprints, some off the map, empty or fully random
	function automatic box_req_t random_box();
		int pick;
		int px;
		int py;
		int len;
		int wid;
		int tall;
		int swap;
		hbp_req_kind_t kind;
		pick = $urandom_range(0, 99);
		kind = $urandom_range(0, 1) ? REQ_PLACE : REQ_QUERY;
		tall = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 24);
		if (pick < 25) begin
			// aligned 4x4 tiles stack flat, so support checks pass often
			len = 4;
			wid = 4;
			px = 4 * $urandom_range(0, 7);
			py = 4 * $urandom_range(0, 7);
		end else if (pick < 75) begin
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, GRID) : $urandom_range(1, 8);
			wid = ($urandom_range(0, 15) == 0) ? $urandom_range(1, GRID) : $urandom_range(1, 8);
			px = $urandom_range(0, GRID - len);
			py = $urandom_range(0, GRID - wid);
		end else if (pick < 90) begin
			// off the map along rows, or along columns after the swap
			px = $urandom_range(0, GRID - 1);
			py = $urandom_range(0, GRID - 1);
			len = $urandom_range(GRID + 1 - px, 63);
			wid = $urandom_range(1, 63);
			if ($urandom_range(0, 1)) begin
				swap = px;
				px = py;
				py = swap;
				swap = len;
				len = wid;
				wid = swap;
			end
		end else if (pick < 95) begin
			// empty footprint
			px = $urandom_range(0, GRID - 1);
			py = $urandom_range(0, GRID - 1);
			len = $urandom_range(0, 63);
			wid = $urandom_range(0, 63);
			if ($urandom_range(0, 1))
				len = 0;
			else
				wid = 0;
		end else begin
			px = $urandom_range(0, GRID - 1);
			py = $urandom_range(0, GRID - 1);
			len = $urandom_range(0, 63);
			wid = $urandom_range(0, 63);
		end
		return make_box(kind, px, py, len, wid, tall);
	endfunction

	// offer one request, in bursts separated by random gaps
	task automatic send_box(input box_req_t b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
		end
		burst_left--;
		req.valid <= 1'b1;
		req.req_type <= b.kind;
		req.pos_x <= b.px;
		req.pos_y <= b.py;
		req.box_len <= b.len;
		req.box_wid <= b.wid;
		req.box_tall <= b.tall;
		do @(posedge clk); while (!req.ready);
		items_sent++;
	endtask

	// stop offering and wait for every predicted response
	task automatic wait_all_results();
		req.valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic write_limit(input logic [CH_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.container_height <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	// response side: stall patterns plus one long hold-off on request
	initial begin : rsp_sink
		rx_mode_t mode;
		int run;
		int held;
		bit hold_done;
		mode = RX_OPEN;
		run = 0;
		hold_done = 1'b0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req && !hold_done) begin
				rsp.ready <= 1'b0;
				for (held = 0; held < LONG_HOLD; held++)
					@(posedge clk);
				hold_done = 1'b1;
			end
			if (run == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				run = $urandom_range(10, 150);
			end
			run--;
			case (mode)
				RX_OPEN: begin
					rsp.ready <= 1'b1;
				end
				RX_COIN: begin
					rsp.ready <= 1'($urandom_range(0, 1));
				end
				RX_MOSTLY: begin
					rsp.ready <= ($urandom_range(0, 7) != 0);
				end
				default: begin
					rsp.ready <= ($urandom_range(0, 3) == 0);
				end
			endcase
		end
	end

	// stimulus
	initial begin : stimulus
		logic [CH_W-1:0] limits [PHASES];
		limits[0] = 10'd300;
		limits[1] = 10'd40;
		limits[2] = 10'd0;
		limits[3] = 10'd1;
		limits[4] = 10'd1023;
		limits[5] = CH_W'($urandom_range(2, 1022));
		limits[6] = 10'd700;
		burst_left = 0;
		items_sent = 0;
		long_hold_req = 1'b0;
		req.valid <= 1'b0;
		req.req_type <= REQ_QUERY;
		req.pos_x <= '0;
		req.pos_y <= '0;
		req.box_len <= '0;
		req.box_wid <= '0;
		req.box_tall <= '0;
		cfg.valid <= 1'b0;
		cfg.container_height <= CH_RESET;
		@(posedge arst_n);
		@(posedge clk);

		// directed: empty floor, full map, tall and zero heights, bounds, support edges
		send_box(make_box(REQ_QUERY, 0, 0, 1, 1, 1));
		send_box(make_box(REQ_PLACE, 0, 0, 32, 32, 5));
		send_box(make_box(REQ_QUERY, 0, 0, 32, 32, 1018));
		send_box(make_box(REQ_QUERY, 0, 0, 32, 32, 1019));
		send_box(make_box(REQ_PLACE, 31, 31, 1, 1, 1023));
		send_box(make_box(REQ_QUERY, 30, 30, 2, 2, 0));
		send_box(make_box(REQ_PLACE, 3, 3, 0, 4, 7));
		send_box(make_box(REQ_QUERY, 3, 3, 4, 0, 7));
		send_box(make_box(REQ_PLACE, 31, 0, 2, 1, 9));
		send_box(make_box(REQ_PLACE, 0, 20, 1, 13, 9));
		send_box(make_box(REQ_PLACE, 31, 31, 63, 63, 1023));
		// place without fit, saturating next to a full cell
		send_box(make_box(REQ_PLACE, 29, 29, 3, 3, 2));
		// support exactly half, then a third
		send_box(make_box(REQ_PLACE, 10, 10, 2, 1, 3));
		send_box(make_box(REQ_QUERY, 10, 10, 2, 2, 1));
		send_box(make_box(REQ_QUERY, 10, 10, 3, 2, 1));
		send_box(make_box(REQ_QUERY, 0, 0, 32, 32, 0));
		send_box(make_box(REQ_QUERY, 0, 0, 0, 0, 0));
		send_box(make_box(REQ_PLACE, 16, 8, 16, 24, 1000));
		send_box(make_box(REQ_PLACE, 16, 8, 16, 24, 100));
		send_box(make_box(REQ_QUERY, 16, 8, 16, 24, 0));

		// random phases, each under its own container height
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_all_results();
			write_limit(limits[phase]);
			if (phase == 1)
				long_hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_box(random_box());
		end

		wait_all_results();
		repeat (SETTLE) @(posedge clk);
		$display("tb_top: %0d requests, %0d in-bounds places, %0d empty or off the map",
			items_sent, placed_count, skipped_count);
		$display("tb_top: %0d responses checked, %0d fits, %0d container heights incl. 0 and 1023",
			responses, fit_count, PHASES + 1);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
